// ----- hw/rtl/mouse_button_event_tracker_assert.svh -----
// Assertion macros used by the checker of the pointer event tracker.
// Each macro expands to one labelled concurrent assertion that is disabled
// while the active-low reset is asserted.
`ifndef MOUSE_BUTTON_EVENT_TRACKER_ASSERT_SVH
`define MOUSE_BUTTON_EVENT_TRACKER_ASSERT_SVH

// Same-cycle implication.
`define MBET_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication.
`define MBET_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// ----- hw/rtl/mbet_pkg.sv -----
`default_nettype none
package mbet_pkg;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_MOVE    = 2'd2
  } event_kind_e;

  typedef enum logic {
    REG_WINDOW = 1'b0,
    REG_ENABLE = 1'b1
  } reg_idx_e;

  localparam logic [31:0] WINDOW_RESET = 32'd500000;
  localparam logic [2:0]  ENABLE_RESET = 3'd7;

  localparam int unsigned NUM_BUTTONS = 3;

  typedef struct packed {
    logic [31:0] window;
    logic [2:0]  enable;
  } cfg_t;

endpackage
`default_nettype wire

// ----- hw/rtl/mbet_cfg_regs.sv -----
`default_nettype none
module mbet_cfg_regs (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output mbet_pkg::cfg_t    cfg_o
);
  import mbet_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  // Registers are word spaced; the byte offset bits are not decoded.
  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_WINDOW: cfg_d.window = pwdata;
        REG_ENABLE: cfg_d.enable = pwdata[2:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WINDOW: prdata = cfg_q.window;
      REG_ENABLE: prdata = {29'd0, cfg_q.enable};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window <= WINDOW_RESET;
      cfg_q.enable <= ENABLE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/mouse_button_event_tracker.sv -----
// Path: a sample beat is registered in the input register, then loaded into the event buffer.
// Throughput: one sample per cycle while each yields at most one event and tready is
// high; a sample with more events stalls the input while they leave, one beat per cycle while tready is high.
// Reset: button, press-time and previous-position state clear to zero, the
// double-click window resets to 500000 and the enable mask to all buttons.
`default_nettype none
module mouse_button_event_tracker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Sample stream.
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [47:0] sample_time, [63:48] pos_x, [79:64] pos_y, [83:80] modifier_keys,
  // [84] left_down, [85] right_down, [86] middle_down, [87] zero
  input  wire logic [87:0]  s_axis_tdata,
  // Event stream.
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [1:0] which_button, [17:2] out_x, [33:18] out_y, [37:34] out_modifiers,
  // [38] is_double, [41:39] held_mask, [47:42] zero
  output logic [47:0]       m_axis_tdata,
  // [1:0] event_kind
  output logic [1:0]        m_axis_tuser,
  // last_of_run
  output logic              m_axis_tlast,
  // Configuration port.
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import mbet_pkg::*;

  // ------------------------------------------------------------------------
  // Configuration registers.
  // ------------------------------------------------------------------------
  cfg_t cfg;

  mbet_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ------------------------------------------------------------------------
  // Input register. A sample waits here until the event buffer can take
  // all the events it causes; the button state is updated in that same cycle.
  // ------------------------------------------------------------------------
  logic        in_valid_q, in_valid_d;
  logic [47:0] in_time_q;
  logic [15:0] in_x_q, in_y_q;
  logic [3:0]  in_mods_q;
  logic [2:0]  in_lev_q;

  logic in_accept;
  logic buf_free;
  logic load;

  assign s_axis_tready = !in_valid_q || buf_free;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign load          = in_valid_q && buf_free;
  assign in_valid_d    = in_accept || (in_valid_q && !load);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_time_q <= s_axis_tdata[47:0];
      in_x_q    <= s_axis_tdata[63:48];
      in_y_q    <= s_axis_tdata[79:64];
      in_mods_q <= s_axis_tdata[83:80];
      in_lev_q  <= s_axis_tdata[86:84];
    end
  end

  // ------------------------------------------------------------------------
  // Tracker state.
  // ------------------------------------------------------------------------
  logic [2:0]  held_q, held_d;
  logic [2:0]  ptv_q, ptv_d;
  logic [47:0] pt_q [NUM_BUTTONS];
  logic [47:0] pt_d [NUM_BUTTONS];
  logic [15:0] prev_x_q, prev_y_q;

  // Event decisions for the sample in the input register.
  logic [2:0]         press, rel, stay, dbl, in_window;
  logic signed [49:0] delta [NUM_BUTTONS];
  logic               moved, want_move;

  // The time difference is signed, so a timestamp that went backwards
  // always lands inside the window. Fifty bits hold any 48-bit difference
  // and the zero-extended window without overflow.
  always_comb begin
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      delta[b]     = $signed({2'b00, in_time_q}) - $signed({2'b00, pt_q[b]});
      in_window[b] = delta[b] < $signed({18'd0, cfg.window});
      press[b]     = !held_q[b] && in_lev_q[b];
      rel[b]       = held_q[b] && !in_lev_q[b];
      stay[b]      = held_q[b] && in_lev_q[b];
      dbl[b]       = press[b] && cfg.enable[b] && ptv_q[b] && in_window[b];
    end
  end

  // Only buttons that were already held and are still down ask for a move,
  // and then only if the pointer really went somewhere.
  assign moved     = (in_x_q != prev_x_q) || (in_y_q != prev_y_q);
  assign want_move = (|stay) && moved;

  // A double click consumes the stored press so that a third quick press
  // counts as a single click again; any other press records its time.
  always_comb begin
    held_d = held_q;
    ptv_d  = ptv_q;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      pt_d[b] = pt_q[b];
    end
    if (load) begin
      held_d = in_lev_q;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        if (press[b]) begin
          ptv_d[b] = !dbl[b];
          if (!dbl[b]) begin
            pt_d[b] = in_time_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= '0;
      ptv_q    <= '0;
      prev_x_q <= '0;
      prev_y_q <= '0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        pt_q[b] <= '0;
      end
    end else begin
      held_q <= held_d;
      ptv_q  <= ptv_d;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        pt_q[b] <= pt_d[b];
      end
      if (load) begin
        prev_x_q <= in_x_q;
        prev_y_q <= in_y_q;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Event buffer. One pending bit per possible event: bits 0 to 2 are the
  // left, right and middle button events and bit 3 the move. Events leave
  // lowest bit first, which is exactly the order left, right, middle, move.
  // ------------------------------------------------------------------------
  logic [3:0]  pend_q, pend_d, pend_rest;
  logic [15:0] ev_x_q, ev_y_q;
  logic [3:0]  ev_mods_q;
  logic [2:0]  ev_rel_q, ev_dbl_q, ev_lev_q;
  logic        pop;

  assign pend_rest     = pend_q & (pend_q - 4'd1);
  assign m_axis_tvalid = |pend_q;
  assign m_axis_tlast  = (pend_rest == 4'd0);
  assign pop           = m_axis_tvalid && m_axis_tready;

  // The buffer takes a new sample once it is empty or its last beat leaves.
  assign buf_free = !m_axis_tvalid || (pop && m_axis_tlast);

  always_comb begin
    pend_d = pend_q;
    if (load) begin
      pend_d = {want_move, press | rel};
    end else if (pop) begin
      pend_d = pend_rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ev_x_q    <= in_x_q;
      ev_y_q    <= in_y_q;
      ev_mods_q <= in_mods_q;
      ev_rel_q  <= rel;
      ev_dbl_q  <= dbl;
      ev_lev_q  <= in_lev_q;
    end
  end

  // ------------------------------------------------------------------------
  // Output formatting for the lowest pending event.
  // ------------------------------------------------------------------------
  event_kind_e out_kind;
  logic [1:0]  out_btn;
  logic [3:0]  out_mods;
  logic        out_dbl;
  logic [2:0]  out_held;
  logic        btn_sel;
  logic [1:0]  btn_idx;

  always_comb begin
    btn_sel = 1'b1;
    btn_idx = 2'd0;
    if (pend_q[0]) begin
      btn_idx = 2'd0;
    end else if (pend_q[1]) begin
      btn_idx = 2'd1;
    end else if (pend_q[2]) begin
      btn_idx = 2'd2;
    end else begin
      btn_sel = 1'b0;
    end
  end

  always_comb begin
    out_kind = KIND_MOVE;
    out_btn  = 2'd0;
    out_mods = 4'd0;
    out_dbl  = 1'b0;
    out_held = ev_lev_q;
    if (btn_sel) begin
      out_btn  = btn_idx;
      out_held = 3'd0;
      if (ev_rel_q[btn_idx]) begin
        out_kind = KIND_RELEASE;
      end else begin
        out_kind = KIND_PRESS;
        out_mods = ev_mods_q;
        out_dbl  = ev_dbl_q[btn_idx];
      end
    end
  end

  assign m_axis_tuser = out_kind;
  assign m_axis_tdata = {6'd0, out_held, out_dbl, out_mods, ev_y_q, ev_x_q, out_btn};

endmodule
`default_nettype wire

// ----- hw/rtl/mbet_checker.sv -----
`default_nettype none
`include "mouse_button_event_tracker_assert.svh"
module mbet_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic [87:0]  s_axis_tdata,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [47:0]  m_axis_tdata,
  input wire logic [1:0]   m_axis_tuser,
  input wire logic         m_axis_tlast,
  input wire logic         psel,
  input wire logic         penable,
  input wire logic         pwrite,
  input wire logic [2:0]   paddr,
  input wire logic [31:0]  pwdata,
  input wire logic [31:0]  prdata,
  input wire logic         pready
);
  import mbet_pkg::*;

  logic is_move, is_release, is_press;
  logic move_ok, is_dbl, press_ok, out_stall;
  logic [50:0] out_beat;

  assign is_move    = m_axis_tvalid && (m_axis_tuser == KIND_MOVE);
  assign is_release = m_axis_tvalid && (m_axis_tuser == KIND_RELEASE);
  assign is_press   = m_axis_tvalid && (m_axis_tuser == KIND_PRESS);

  assign move_ok   = (m_axis_tdata[1:0] == 2'd0) && (m_axis_tdata[38:34] == 5'd0) && m_axis_tlast;
  assign is_dbl    = m_axis_tvalid && m_axis_tdata[38];
  assign press_ok  = is_press && (m_axis_tdata[41:39] == 3'd0);
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_beat  = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

  // A move carries no button, modifiers or double flag, and always ends the run.
  `MBET_ASSERT_IMPL(a_move_clean, clk_i, rst_ni, is_move, move_ok)

  // A release carries neither modifiers nor a held mask.
  `MBET_ASSERT_IMPL(a_release_clean, clk_i, rst_ni, is_release, m_axis_tdata[41:34] == 8'd0)

  // Only a press can be a double click, and a double-click press never reports held buttons.
  `MBET_ASSERT_IMPL(a_double_on_press, clk_i, rst_ni, is_dbl, press_ok)

  // A stalled event beat holds.
  `MBET_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(out_beat))

  // Unused by the properties above.
  logic unused_ok;
  assign unused_ok = ^{s_axis_tvalid, s_axis_tready, s_axis_tdata, psel, penable, pwrite,
                       paddr, pwdata, prdata, pready};

endmodule

bind mouse_button_event_tracker mbet_checker u_mbet_checker (.*);
`default_nettype wire

// ----- dv/mouse_button_event_tracker_checker.sv -----
module mouse_button_event_tracker_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // [47:0] sample_time, [63:48] pos_x, [79:64] pos_y, [83:80] modifier_keys,
  // [84] left_down, [85] right_down, [86] middle_down, [87] zero
  input  logic [87:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] which_button, [17:2] out_x, [33:18] out_y, [37:34] out_modifiers,
  // [38] is_double, [41:39] held_mask, [47:42] zero
  input  logic [47:0] m_axis_tdata,
  // [1:0] event_kind
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned mismatch_count_o,
  output int unsigned pending_events_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import mbet_pkg::*;

  typedef struct {
    event_kind_e        kind;
    logic [1:0]         button;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [3:0]         mods;
    logic               dbl;
    logic [2:0]         held;
    logic               last;
  } ptr_event_t;

  logic [31:0]            window_q;
  logic [2:0]             enable_q;
  logic [NUM_BUTTONS-1:0] held_q;
  logic [NUM_BUTTONS-1:0] stamp_valid_q;
  logic [47:0]            press_stamp_q [NUM_BUTTONS];
  logic [15:0]            prev_x_q;
  logic [15:0]            prev_y_q;

  ptr_event_t  expected_events [$];
  int unsigned mismatches = 0;

  task automatic flag_mismatch(input string what, input logic [47:0] got,
                               input logic [47:0] want);
    if (mismatches < 100) begin
      $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  // Turns one pointer sample into the events it should cause and advances the
  // tracked button, press-time and position state.
  function automatic void track_sample(input logic [87:0] beat);
    logic [47:0] stamp;
    logic [15:0] x;
    logic [15:0] y;
    logic [3:0]  mods;
    logic [2:0]  levels;
    logic        move_wanted;
    logic        dbl;
    longint      delta;
    ptr_event_t  ev;
    ptr_event_t  run [$];
    stamp       = beat[47:0];
    x           = beat[63:48];
    y           = beat[79:64];
    mods        = beat[83:80];
    levels      = beat[86:84];
    move_wanted = 1'b0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      ev.kind   = KIND_PRESS;
      ev.button = 2'(b);
      ev.x      = x;
      ev.y      = y;
      ev.mods   = '0;
      ev.dbl    = 1'b0;
      ev.held   = '0;
      ev.last   = 1'b0;
      if (!held_q[b] && levels[b]) begin
        dbl = 1'b0;
        if (enable_q[b] && stamp_valid_q[b]) begin
          // The difference is signed, so a clock running backwards always
          // lands inside the window.
          delta = longint'({16'd0, stamp}) - longint'({16'd0, press_stamp_q[b]});
          dbl   = delta < longint'({32'd0, window_q});
        end
        ev.mods = mods;
        ev.dbl  = dbl;
        run.push_back(ev);
        stamp_valid_q[b] = !dbl;
        if (!dbl) begin
          press_stamp_q[b] = stamp;
        end
        held_q[b] = 1'b1;
      end else if (held_q[b] && !levels[b]) begin
        ev.kind = KIND_RELEASE;
        run.push_back(ev);
        held_q[b] = 1'b0;
      end else if (held_q[b]) begin
        move_wanted = 1'b1;
      end
    end
    if (move_wanted && (x != prev_x_q || y != prev_y_q)) begin
      ev.kind   = KIND_MOVE;
      ev.button = '0;
      ev.mods   = '0;
      ev.dbl    = 1'b0;
      ev.held   = levels;
      run.push_back(ev);
    end
    prev_x_q = x;
    prev_y_q = y;
    if (run.size() != 0) begin
      run[run.size() - 1].last = 1'b1;
    end
    foreach (run[i]) begin
      expected_events.push_back(run[i]);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    ptr_event_t want;
    if (!rst_ni) begin
      window_q      = WINDOW_RESET;
      enable_q      = ENABLE_RESET;
      held_q        = '0;
      stamp_valid_q = '0;
      foreach (press_stamp_q[b]) begin
        press_stamp_q[b] = '0;
      end
      prev_x_q = '0;
      prev_y_q = '0;
      expected_events.delete();
      pending_events_o <= 0;
    end else begin
      // Outputs are checked before the input is predicted, so a stray event
      // beat can never be matched against a sample taken at the same edge.
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_events.size() == 0) begin
          flag_mismatch("unexpected event beat", m_axis_tdata, '0);
        end else begin
          want = expected_events.pop_front();
          if (m_axis_tuser !== want.kind) begin
            flag_mismatch("event_kind", m_axis_tuser, want.kind);
          end
          if (m_axis_tdata[1:0] !== want.button) begin
            flag_mismatch("which_button", m_axis_tdata[1:0], want.button);
          end
          if (m_axis_tdata[17:2] !== want.x) begin
            flag_mismatch("out_x", m_axis_tdata[17:2], want.x);
          end
          if (m_axis_tdata[33:18] !== want.y) begin
            flag_mismatch("out_y", m_axis_tdata[33:18], want.y);
          end
          if (m_axis_tdata[37:34] !== want.mods) begin
            flag_mismatch("out_modifiers", m_axis_tdata[37:34], want.mods);
          end
          if (m_axis_tdata[38] !== want.dbl) begin
            flag_mismatch("is_double", m_axis_tdata[38], want.dbl);
          end
          if (m_axis_tdata[41:39] !== want.held) begin
            flag_mismatch("held_mask", m_axis_tdata[41:39], want.held);
          end
          if (m_axis_tlast !== want.last) begin
            flag_mismatch("last_of_run", m_axis_tlast, want.last);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        track_sample(s_axis_tdata);
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_WINDOW, 2'b00}) begin
          window_q = pwdata;
        end else if (paddr == {REG_ENABLE, 2'b00}) begin
          enable_q = pwdata[2:0];
        end
      end
      pending_events_o <= expected_events.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

// ----- dv/mouse_button_event_tracker_tb.sv -----
module mouse_button_event_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mbet_pkg::*;

  // How long the event sink holds off in one go to make the block back up,
  // how long the bench lets the pipeline empty before it touches a register
  // or gives its verdict, and how many cycles without a single beat on either
  // stream are tolerated before the run is declared hung.
  localparam int unsigned SQUEEZE_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned PHASES          = 6;
  localparam int unsigned ITEMS_PER_PHASE = 58;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned mismatch_count;
  int unsigned pending_events;
  int unsigned quiet_cycles   = 0;
  int unsigned squeezes_asked = 0;

  // Sender pacing: tx_steady flips now and then to give runs of back-to-back
  // beats, tx_hold_gaps forces them while the sink is being held off.
  logic tx_steady    = 1'b0;
  logic tx_hold_gaps = 1'b0;

  always #10 clk_i = ~clk_i;

  mouse_button_event_tracker dut (.*);

  mouse_button_event_tracker_checker u_checker (
    .mismatch_count_o (mismatch_count),
    .pending_events_o (pending_events),
    .*
  );

  // Offers one pointer sample after a random pause and returns at the edge
  // where the beat is taken. Every call starts right after a rising edge, so
  // each input changes at most once per time step.
  task automatic send_sample(input logic [47:0] stamp, input logic [15:0] x, y,
                             input logic [3:0] mods, input logic [2:0] levels);
    int unsigned gap;
    if ($urandom_range(0, 24) == 0) begin
      tx_steady = !tx_steady;
    end
    gap = (tx_steady || tx_hold_gaps) ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, levels, mods, y, x, stamp};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Writes both registers back to back. psel stays high between the two
  // transfers, so only penable drops for the second setup cycle.
  task automatic configure(input logic [31:0] window, input logic [2:0] mask);
    reg_idx_e    order [2];
    logic [31:0] value [2];
    order[0] = REG_WINDOW;
    value[0] = window;
    order[1] = REG_ENABLE;
    value[1] = {29'd0, mask};
    psel   <= 1'b1;
    pwrite <= 1'b1;
    foreach (order[i]) begin
      paddr   <= {order[i], 2'b00};
      pwdata  <= value[i];
      penable <= 1'b0;
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stops offering samples and waits until every predicted event has come
  // out. A sample that causes no event leaves nothing to wait for, so a
  // further wait of DRAIN_CYCLES lets it pass through before the caller goes on.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_events != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Event sink. After every beat it draws a stall of its own; now and then it
  // switches to a run with no stalls at all. When the stimulus asks for a
  // squeeze it holds tready low for a long stretch, counted here.
  initial begin : event_sink
    int unsigned stall_left;
    int unsigned squeezes_served;
    logic        relaxed;
    stall_left      = 0;
    squeezes_served = 0;
    relaxed         = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if ($urandom_range(0, 29) == 0) begin
          relaxed = !relaxed;
        end
        stall_left = relaxed ? 0 : $urandom_range(0, 19);
      end
      if (squeezes_asked != squeezes_served) begin
        squeezes_served++;
        stall_left = SQUEEZE_CYCLES;
      end
      m_axis_tready <= (stall_left == 0);
      if (stall_left != 0) begin
        stall_left--;
      end
    end
  end

  // Hang detection: any beat on either stream restarts the count. The longest
  // quiet stretch in a healthy run is the squeeze, well under the limit.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("mouse_button_event_tracker verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [31:0] windows [PHASES];
    logic [2:0]  masks [PHASES];
    logic [47:0] now_stamp;
    logic [15:0] x_now;
    logic [15:0] y_now;
    logic [2:0]  levels_now;
    logic [31:0] step_cap;
    int unsigned pick;
    int unsigned btn;

    // Settings per random phase: a zero window (only a clock running backwards
    // gives a double click), the widest window, all buttons disabled, a narrow
    // window with some buttons off, then two random windows, the last for the right button only.
    windows    = '{32'd0, 32'hFFFF_FFFF, WINDOW_RESET, 32'd1000, 32'd0, 32'd0};
    masks      = '{3'b111, 3'b111, 3'b000, 3'b101, 3'b000, 3'b010};
    windows[4] = $urandom_range(0, 2_000_000);
    windows[5] = $urandom;
    masks[4]   = 3'($urandom);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, run with the reset settings (500 ms window, all buttons
    // enabled). A sample with nothing happening comes first.
    send_sample(48'd1000, 16'd0, 16'd0, 4'h0, 3'b000);
    // A first press is a single click and stores its time; the same position
    // with the button still held causes nothing.
    send_sample(48'd2000, 16'd100, 16'hFF9C, 4'hF, 3'b001);
    send_sample(48'd3000, 16'd100, 16'hFF9C, 4'h0, 3'b001);
    // A held button and a new position give a move, here to the corner.
    send_sample(48'd4000, 16'h7FFF, 16'h8000, 4'hA, 3'b001);
    send_sample(48'd5000, 16'h7FFF, 16'h8000, 4'h3, 3'b000);
    // A quick second press is a double click and clears the stored time, so
    // the third press is a single click once more.
    send_sample(48'd6000, 16'h8000, 16'h7FFF, 4'h5, 3'b001);
    send_sample(48'd7000, 16'h8000, 16'h7FFF, 4'h0, 3'b000);
    send_sample(48'd8000, 16'd1, 16'd1, 4'h0, 3'b001);
    // Two buttons pressed together while the first is held: two presses and
    // a move, which the newly pressed buttons do not request on their own.
    send_sample(48'd9000, 16'd2, 16'd2, 4'h6, 3'b111);
    send_sample(48'd9500, 16'd3, 16'd3, 4'h0, 3'b000);
    // Three double clicks in one sample, and no move since nothing was held.
    send_sample(48'd9600, 16'd4, 16'd4, 4'h9, 3'b111);
    // The clock runs backwards from here: a release with a move, a single
    // press with a move, a release without one, then a press with a negative
    // difference, which counts as a double click.
    send_sample(48'd100, 16'd5, 16'd5, 4'h0, 3'b110);
    send_sample(48'd50, 16'd6, 16'd6, 4'hC, 3'b111);
    send_sample(48'd60, 16'd6, 16'd6, 4'h0, 3'b110);
    send_sample(48'd10, 16'd6, 16'd6, 4'h1, 3'b111);
    // Largest timestamp, then a wrap to zero that makes the difference hugely
    // negative.
    send_sample(48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 4'h0, 3'b000);
    send_sample(48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 4'hF, 3'b001);
    send_sample(48'd0, 16'd0, 16'd0, 4'h0, 3'b000);
    send_sample(48'd0, 16'd0, 16'd0, 4'h8, 3'b001);
    send_sample(48'd1, 16'd0, 16'd0, 4'h0, 3'b000);
    settle();

    now_stamp  = 48'd1;
    x_now      = '0;
    y_now      = '0;
    levels_now = '0;

    for (int phase = 0; phase < PHASES; phase++) begin
      configure(windows[phase], masks[phase]);
      step_cap = (windows[phase] > 32'd1_000_000) ? 32'd2_000_000 : 2 * windows[phase];
      // In the second phase the sink stops for a long while and the source
      // keeps offering samples without pause, so the block has to stall.
      if (phase == 1) begin
        squeezes_asked <= squeezes_asked + 1;
        tx_hold_gaps = 1'b1;
      end
      for (int item = 0; item < ITEMS_PER_PHASE; item++) begin
        if (item == 40) begin
          tx_hold_gaps = 1'b0;
        end
        // Mostly steps around the window so presses land on both sides of
        // it; also repeated stamps, backward steps, long jumps and stamps
        // drawn over the whole range.
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          now_stamp = now_stamp + 48'($urandom_range(0, step_cap));
        end else if (pick < 75) begin
          now_stamp = now_stamp;
        end else if (pick < 85) begin
          now_stamp = now_stamp - 48'($urandom_range(1, 1_000_000));
        end else if (pick < 95) begin
          now_stamp = now_stamp + 48'($urandom);
        end else begin
          now_stamp = {16'($urandom), $urandom};
        end
        // Buttons usually change one at a time, which builds press and
        // release pairs; sometimes they stay or all change at random.
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          btn = $urandom_range(0, 2);
          levels_now[btn] = ~levels_now[btn];
        end else if (pick >= 85) begin
          levels_now = 3'($urandom);
        end
        // The position often stays put, to reach the case of held buttons
        // without a move, otherwise it drifts or jumps anywhere.
        pick = $urandom_range(0, 99);
        if (pick >= 40 && pick < 80) begin
          x_now = x_now + 16'($urandom_range(0, 64)) - 16'd32;
          y_now = y_now + 16'($urandom_range(0, 64)) - 16'd32;
        end else if (pick >= 80) begin
          x_now = 16'($urandom);
          y_now = 16'($urandom);
        end
        send_sample(now_stamp, x_now, y_now, 4'($urandom), levels_now);
      end
      tx_hold_gaps = 1'b0;
      settle();
    end

    if (mismatch_count == 0) begin
      $display("mouse_button_event_tracker verification clean");
    end else begin
      $display("mouse_button_event_tracker verification failed");
    end
    $finish;
  end

endmodule
